FILE: src/lfo_pkg.sv
// Package with shared types, constants and tables of the oscillator.
`timescale 1ns / 1ps
`default_nettype none
package lfo_pkg;

	localparam int SineBits = 16;
	localparam int CordicMax = 24;
	localparam int CordicIters = (SineBits > CordicMax) ? CordicMax : SineBits;
	localparam int IterW = $clog2(CordicMax + 1);

	// Register indexes of the configuration port.
	localparam logic [2:0] REG_WAVEFORM = 3'd0;
	localparam logic [2:0] REG_PERIOD = 3'd1;
	localparam logic [2:0] REG_AMPLITUDE = 3'd2;
	localparam logic [2:0] REG_AMP_MAX = 3'd3;
	localparam logic [2:0] REG_PHASE_SCALE = 3'd4;
	localparam logic [2:0] REG_START_COUNT = 3'd5;

	// Waveform codes.
	localparam logic [2:0] WAVE_NONE = 3'd0;
	localparam logic [2:0] WAVE_SINE = 3'd1;
	localparam logic [2:0] WAVE_COSINE = 3'd2;
	localparam logic [2:0] WAVE_TRIANGLE = 3'd3;
	localparam logic [2:0] WAVE_RAMP_UP = 3'd4;
	localparam logic [2:0] WAVE_RAMP_DOWN = 3'd5;

	localparam logic signed [33:0] CORDIC_X0 = 34'sd652032874;

	typedef enum logic [3:0] {
		ST_IDLE,
		ST_MOD,
		ST_DIV,
		ST_ANGLE,
		ST_CORDIC,
		ST_MUL,
		ST_ROUND,
		ST_OUT
	} lfo_state_t;

	// Arctangent of 2^-i in 2^-32 turns.
	function automatic logic [31:0] atan_turns(input logic [IterW-1:0] i);
		logic [31:0] r;
		begin
			case (i)
				5'd0: r = 32'd536870912;
				5'd1: r = 32'd316933406;
				5'd2: r = 32'd167458907;
				5'd3: r = 32'd85004756;
				5'd4: r = 32'd42667331;
				5'd5: r = 32'd21354465;
				5'd6: r = 32'd10680862;
				5'd7: r = 32'd5340245;
				5'd8: r = 32'd2670675;
				5'd9: r = 32'd1335087;
				5'd10: r = 32'd667544;
				5'd11: r = 32'd333772;
				5'd12: r = 32'd166886;
				5'd13: r = 32'd83443;
				5'd14: r = 32'd41721;
				5'd15: r = 32'd20860;
				5'd16: r = 32'd10430;
				5'd17: r = 32'd5215;
				5'd18: r = 32'd2607;
				5'd19: r = 32'd1303;
				5'd20: r = 32'd651;
				5'd21: r = 32'd325;
				5'd22: r = 32'd162;
				5'd23: r = 32'd81;
				default: r = 32'd0;
			endcase
			return r;
		end
	endfunction

endpackage
`default_nettype wire

FILE: src/low_frequency_oscillator.sv
// Top level of the low frequency oscillator with sequencer and output stage.
// A sine or cosine sample passes 32 remainder and 16 fraction steps, 16 CORDIC steps,
// handoffs, multiply and round; the other waveforms skip the CORDIC, and a zero period
// goes straight to the output with a zero sample; a repeated count is taken and yields no sample.
// Throughput: one transaction at a time; the next is taken after the sample leaves.
// Reset: arst_n clears the registers to their defaults and last_count to zero.
`timescale 1ns / 1ps
`default_nettype none
module low_frequency_oscillator
	import lfo_pkg::*;
(
	input wire logic clk,
	input wire logic arst_n,
	input wire logic cfg_we,
	input wire logic [2:0] cfg_index,
	input wire logic [31:0] cfg_data,
	input wire logic in_valid,
	output logic in_ready,
	input wire logic [31:0] tick_count,
	output logic out_valid,
	input wire logic out_ready,
	output logic signed [15:0] level
);
	logic [2:0] waveform_q;
	logic [15:0] period_q;
	logic signed [15:0] amplitude_q;
	logic signed [15:0] amp_max_q;
	logic [15:0] phase_scale_q;
	logic [31:0] start_count_q;
	logic [31:0] last_count_q;

	lfo_state_t state_q, state_d;
	logic [31:0] count_q;
	logic [15:0] ratio_q;
	logic [31:0] angle_q;
	logic signed [49:0] prod_q;
	logic [5:0] rnd_sh_q;
	logic signed [15:0] res_q;
	logic cor_go_q;

	logic div_start, div_frac, div_done;
	logic [31:0] div_dividend;
	logic [15:0] div_result;
	logic cor_done;
	logic signed [33:0] cor_sin, cor_cos;

	logic accept;
	logic [31:0] rel;
	logic [31:0] prod_ang;
	logic signed [49:0] rounded;
	logic signed [49:0] shifted;

	// Configuration writes.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			waveform_q <= WAVE_NONE;
			period_q <= '0;
			amplitude_q <= 16'sd256;
			amp_max_q <= 16'sd256;
			phase_scale_q <= 16'd256;
			start_count_q <= '0;
		end else if (cfg_we) begin
			unique case (cfg_index)
				REG_WAVEFORM: waveform_q <= cfg_data[2:0];
				REG_PERIOD: period_q <= cfg_data[15:0];
				REG_AMPLITUDE: amplitude_q <= cfg_data[15:0];
				REG_AMP_MAX: amp_max_q <= cfg_data[15:0];
				REG_PHASE_SCALE: phase_scale_q <= cfg_data[15:0];
				REG_START_COUNT: start_count_q <= cfg_data;
				default: ;
			endcase
		end
	end

	assign in_ready = (state_q == ST_IDLE) && !out_valid;
	assign accept = in_valid && in_ready;
	assign rel = count_q - start_count_q;
	assign div_dividend = (state_q == ST_MOD) ? rel : {16'd0, div_result};
	assign prod_ang = 32'(div_result) * 32'(phase_scale_q);

	// Rounding adder and arithmetic shift of the product.
	assign rounded = prod_q + (50'sd1 <<< (rnd_sh_q - 6'd1));
	assign shifted = rounded >>> rnd_sh_q;

	// Sequencer next state.
	always_comb begin
		state_d = state_q;
		div_start = 1'b0;
		div_frac = 1'b0;
		unique case (state_q)
			ST_IDLE: if (accept && tick_count != last_count_q) begin
				state_d = (period_q == 16'd0) ? ST_OUT : ST_MOD;
			end
			ST_MOD: begin
				div_start = 1'b1;
				state_d = ST_DIV;
			end
			ST_DIV: if (div_done) begin
				div_start = 1'b1;
				div_frac = 1'b1;
				state_d = ST_ANGLE;
			end
			ST_ANGLE: begin
				div_frac = 1'b1;
				if (div_done) begin
					state_d = (waveform_q == WAVE_SINE || waveform_q == WAVE_COSINE)
						? ST_CORDIC : ST_MUL;
				end
			end
			ST_CORDIC: if (cor_done) state_d = ST_MUL;
			ST_MUL: state_d = ST_ROUND;
			ST_ROUND: state_d = ST_OUT;
			ST_OUT: state_d = ST_IDLE;
			default: state_d = ST_IDLE;
		endcase
	end

	// Control registers and the output register.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= ST_IDLE;
			last_count_q <= '0;
			out_valid <= 1'b0;
			level <= '0;
		end else begin
			state_q <= state_d;
			if (state_q == ST_IDLE && accept && tick_count != last_count_q &&
				period_q != 16'd0) begin
				last_count_q <= tick_count;
			end
			if (state_q == ST_OUT) begin
				out_valid <= 1'b1;
				level <= res_q;
			end else if (out_valid && out_ready) begin
				out_valid <= 1'b0;
			end
		end
	end

	// Datapath registers; the CORDIC start is registered alongside the angle.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) cor_go_q <= 1'b0;
		else cor_go_q <= (state_q == ST_ANGLE) && div_done &&
			(waveform_q == WAVE_SINE || waveform_q == WAVE_COSINE);
	end

	always_ff @(posedge clk) begin
		if (accept) begin
			count_q <= tick_count;
			res_q <= '0;
		end
		if (state_q == ST_ANGLE && div_done) begin
			ratio_q <= div_result;
			angle_q <= {prod_ang[24:0], 7'd0};
		end
		if (state_q == ST_MUL) begin
			unique case (waveform_q) inside
				WAVE_SINE, WAVE_COSINE: begin
					prod_q <= 50'((waveform_q == WAVE_COSINE) ? cor_cos : cor_sin) *
						50'(amplitude_q);
					rnd_sh_q <= 6'd30;
				end
				WAVE_TRIANGLE: begin
					prod_q <= 50'(ratio_q[15] ?
						(34'sd131072 - $signed({17'd0, ratio_q, 1'b0})) :
						$signed({17'd0, ratio_q, 1'b0})) * 50'(amplitude_q);
					rnd_sh_q <= 6'd16;
				end
				WAVE_RAMP_UP: begin
					prod_q <= $signed({34'd0, ratio_q}) * 50'(amplitude_q);
					rnd_sh_q <= 6'd16;
				end
				WAVE_RAMP_DOWN: begin
					prod_q <= (50'(amp_max_q) <<< 16) -
						$signed({34'd0, ratio_q}) * 50'(amplitude_q);
					rnd_sh_q <= 6'd16;
				end
				default: begin
					prod_q <= '0;
					rnd_sh_q <= 6'd1;
				end
			endcase
		end
		if (state_q == ST_ROUND) begin
			if (shifted > 50'sd32767) res_q <= 16'sd32767;
			else if (shifted < -50'sd32768) res_q <= -16'sd32768;
			else res_q <= shifted[15:0];
		end
	end

	lfo_divider u_div (
		.clk(clk), .arst_n(arst_n), .start(div_start), .frac_mode(div_frac),
		.dividend(div_dividend), .divisor(period_q), .done(div_done),
		.result(div_result)
	);

	lfo_cordic u_cordic (
		.clk(clk), .arst_n(arst_n), .start(cor_go_q), .angle(angle_q),
		.done(cor_done), .sin_out(cor_sin), .cos_out(cor_cos)
	);

	// Checks on the sequencer and the output register.
	assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && !out_ready |=> out_valid && $stable(level))
		else $error("result dropped while stalled");
	assert property (@(posedge clk) disable iff (!arst_n)
		accept |-> state_q == ST_IDLE)
		else $error("transaction taken while busy");
	assert property (@(posedge clk) disable iff (!arst_n)
		state_q == ST_OUT |=> out_valid)
		else $error("finished sample not shown");
	assert property (@(posedge clk) disable iff (!arst_n)
		cor_done |-> state_q == ST_CORDIC)
		else $error("CORDIC finished outside its phase");
endmodule
`default_nettype wire

FILE: src/lfo_divider.sv
// Bit-serial restoring divider: remainder mode and fraction mode.
`timescale 1ns / 1ps
`default_nettype none
module lfo_divider
	import lfo_pkg::*;
(
	input wire logic clk,
	input wire logic arst_n,
	input wire logic start,
	input wire logic frac_mode,
	input wire logic [31:0] dividend,
	input wire logic [15:0] divisor,
	output logic done,
	output logic [15:0] result
);
	// In remainder mode 32 dividend bits shift in; in fraction mode the
	// remainder (below the divisor) shifts in 16 zero bits, quotient kept.
	logic [31:0] shift_q;
	logic [16:0] rem_q;
	logic [15:0] quot_q;
	logic [5:0] cnt_q;
	logic busy_q;
	logic mode_q;
	logic [16:0] trial;
	logic [16:0] diff;
	logic take;

	assign trial = {rem_q[15:0], shift_q[31]};
	assign diff = trial - {1'b0, divisor};
	assign take = !diff[16];

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			busy_q <= 1'b0;
			done <= 1'b0;
			cnt_q <= '0;
		end else begin
			done <= 1'b0;
			if (start) begin
				busy_q <= 1'b1;
				cnt_q <= frac_mode ? 6'd16 : 6'd32;
			end else if (busy_q) begin
				cnt_q <= cnt_q - 6'd1;
				if (cnt_q == 6'd1) begin
					busy_q <= 1'b0;
					done <= 1'b1;
				end
			end
		end
	end

	// Datapath: one quotient bit per cycle.
	always_ff @(posedge clk) begin
		if (start) begin
			shift_q <= frac_mode ? 32'd0 : dividend;
			rem_q <= frac_mode ? {1'b0, dividend[15:0]} : 17'd0;
			quot_q <= '0;
			mode_q <= frac_mode;
		end else if (busy_q) begin
			shift_q <= {shift_q[30:0], 1'b0};
			rem_q <= take ? diff : trial;
			quot_q <= {quot_q[14:0], take};
		end
	end

	// The mode of the running division picks the quotient or the remainder.
	assign result = mode_q ? quot_q : rem_q[15:0];
endmodule
`default_nettype wire

FILE: src/lfo_cordic.sv
// Iterative circular CORDIC, one rotation step per cycle.
`timescale 1ns / 1ps
`default_nettype none
module lfo_cordic
	import lfo_pkg::*;
(
	input wire logic clk,
	input wire logic arst_n,
	input wire logic start,
	input wire logic [31:0] angle,
	output logic done,
	output logic signed [33:0] sin_out,
	output logic signed [33:0] cos_out
);
	logic signed [33:0] x_q, y_q;
	logic signed [32:0] z_q;
	logic neg_q;
	logic [IterW-1:0] it_q;
	logic busy_q;
	logic [31:0] ang_f;
	logic flip;
	logic signed [33:0] dx, dy;
	logic signed [32:0] at;

	assign flip = angle[31] ^ angle[30];
	assign ang_f = flip ? {~angle[31], angle[30:0]} : angle;
	assign dx = y_q >>> it_q;
	assign dy = x_q >>> it_q;
	assign at = $signed({1'b0, atan_turns(it_q)});

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			busy_q <= 1'b0;
			done <= 1'b0;
			it_q <= '0;
		end else begin
			done <= 1'b0;
			if (start) begin
				busy_q <= 1'b1;
				it_q <= '0;
			end else if (busy_q) begin
				it_q <= it_q + 1'b1;
				if (it_q == IterW'(CordicIters - 1)) begin
					busy_q <= 1'b0;
					done <= 1'b1;
				end
			end
		end
	end

	// Rotation datapath.
	always_ff @(posedge clk) begin
		if (start) begin
			x_q <= CORDIC_X0;
			y_q <= '0;
			z_q <= $signed({ang_f[31], ang_f});
			neg_q <= flip;
		end else if (busy_q) begin
			if (!z_q[32]) begin
				x_q <= x_q - dx;
				y_q <= y_q + dy;
				z_q <= z_q - at;
			end else begin
				x_q <= x_q + dx;
				y_q <= y_q - dy;
				z_q <= z_q + at;
			end
		end
	end

	assign sin_out = neg_q ? -y_q : y_q;
	assign cos_out = neg_q ? -x_q : x_q;
endmodule
`default_nettype wire

FILE: tb/tb_top.sv
// Self-checking testbench for the low frequency oscillator.
`timescale 1ns / 1ps
module tb_top
	import lfo_pkg::*;
;

	logic clk;
	logic arst_n;
	logic cfg_we;
	logic [2:0] cfg_index;
	logic [31:0] cfg_data;
	logic in_valid;
	logic in_ready;
	logic [31:0] tick_count;
	logic out_valid;
	logic out_ready;
	logic signed [15:0] level;

	low_frequency_oscillator uut (
		.clk(clk),
		.arst_n(arst_n),
		.cfg_we(cfg_we),
		.cfg_index(cfg_index),
		.cfg_data(cfg_data),
		.in_valid(in_valid),
		.in_ready(in_ready),
		.tick_count(tick_count),
		.out_valid(out_valid),
		.out_ready(out_ready),
		.level(level)
	);

	// Shadow copy of the oscillator registers and state.
	logic [2:0] sh_wave;
	logic [15:0] sh_period;
	logic signed [15:0] sh_amp;
	logic signed [15:0] sh_amp_max;
	logic [15:0] sh_scale;
	logic [31:0] sh_start;
	logic [31:0] sh_last;

	logic signed [15:0] expected_levels[$];
	int mismatches;
	bit quiet_out;
	bit quiet_in;

	localparam logic [31:0] ATAN_TBL[24] = '{
		32'd536870912, 32'd316933406, 32'd167458907, 32'd85004756, 32'd42667331,
		32'd21354465, 32'd10680862, 32'd5340245, 32'd2670675, 32'd1335087,
		32'd667544, 32'd333772, 32'd166886, 32'd83443, 32'd41721, 32'd20860,
		32'd10430, 32'd5215, 32'd2607, 32'd1303, 32'd651, 32'd325, 32'd162, 32'd81
	};

	// Clock generation.
	initial clk = 1'b0;
	always begin
		#6 clk = 1'b1;
		#6 clk = 1'b0;
	end

	// Floor of a rounded shift, saturated to 16 bits.
	function automatic logic signed [15:0] round_sat(input longint num, input int k);
		longint v;
		v = (num + (longint'(1) <<< (k - 1))) >>> k;
		if (v > 32767)
			v = 32767;
		if (v < -32768)
			v = -32768;
		return 16'(v);
	endfunction

	// Rotation-mode sine or cosine of an angle in 2^-32 turns, Q1.30.
	function automatic longint rotate_angle(input logic [31:0] ang, input bit cos_out);
		bit flip;
		longint x, y, z, dx, dy, r;
		flip = 1'b0;
		x = 652032874;
		y = 0;
		if (((ang + 32'h4000_0000) & 32'h8000_0000) != 0) begin
			ang = ang ^ 32'h8000_0000;
			flip = 1'b1;
		end
		z = longint'($signed(ang));
		for (int i = 0; i < CordicIters; i++) begin
			dx = y >>> i;
			dy = x >>> i;
			if (z >= 0) begin
				x = x - dx;
				y = y + dy;
				z = z - longint'(ATAN_TBL[i]);
			end else begin
				x = x + dx;
				y = y - dy;
				z = z + longint'(ATAN_TBL[i]);
			end
		end
		r = cos_out ? x : y;
		return flip ? -r : r;
	endfunction

	// Works out the sample for one tick count and updates the shadow state.
	function automatic void predict_level(input logic [31:0] cnt);
		logic [31:0] ph;
		logic [31:0] ratio;
		logic [63:0] prod;
		logic [31:0] ang;
		longint a, t;
		logic signed [15:0] lv;
		if (cnt == sh_last)
			return;
		if (sh_period == 0) begin
			expected_levels.push_back(16'sd0);
			return;
		end
		sh_last = cnt;
		ph = (cnt - sh_start) % {16'd0, sh_period};
		ratio = 32'(({32'd0, ph} << 16) / {48'd0, sh_period});
		a = longint'(sh_amp);
		case (sh_wave) inside
			WAVE_SINE, WAVE_COSINE: begin
				prod = {32'd0, ratio} * {48'd0, sh_scale};
				ang = 32'(prod << 7);
				lv = round_sat(rotate_angle(ang, sh_wave == WAVE_COSINE) * a, 30);
			end
			WAVE_TRIANGLE: begin
				t = (ratio < 32768) ? 2 * longint'(ratio) : 131072 - 2 * longint'(ratio);
				lv = round_sat(t * a, 16);
			end
			WAVE_RAMP_UP: lv = round_sat(longint'(ratio) * a, 16);
			WAVE_RAMP_DOWN:
				lv = round_sat(longint'(sh_amp_max) * 65536 - longint'(ratio) * a, 16);
			default: lv = 16'sd0;
		endcase
		expected_levels.push_back(lv);
	endfunction

	// Writes one register once every sample in flight has come out.
	task automatic write_reg(input logic [2:0] idx, input logic [31:0] val);
		in_valid <= 1'b0;
		while (expected_levels.size() != 0)
			@(posedge clk);
		@(posedge clk);
		cfg_we <= 1'b1;
		cfg_index <= idx;
		cfg_data <= val;
		@(posedge clk);
		cfg_we <= 1'b0;
		case (idx)
			REG_WAVEFORM: sh_wave = val[2:0];
			REG_PERIOD: sh_period = val[15:0];
			REG_AMPLITUDE: sh_amp = val[15:0];
			REG_AMP_MAX: sh_amp_max = val[15:0];
			REG_PHASE_SCALE: sh_scale = val[15:0];
			REG_START_COUNT: sh_start = val;
			default: ;
		endcase
	endtask

	task automatic set_all(input logic [2:0] w, input logic [15:0] p, input logic [15:0] a,
			input logic [15:0] m, input logic [15:0] s, input logic [31:0] st);
		write_reg(REG_WAVEFORM, {29'd0, w});
		write_reg(REG_PERIOD, {16'd0, p});
		write_reg(REG_AMPLITUDE, {16'd0, a});
		write_reg(REG_AMP_MAX, {16'd0, m});
		write_reg(REG_PHASE_SCALE, {16'd0, s});
		write_reg(REG_START_COUNT, st);
	endtask

	// Sends one tick count transaction, at times after a random gap.
	// Valid stays high on return; the next caller drives it on.
	task automatic send_tick(input logic [31:0] cnt);
		if (!quiet_in && $urandom_range(99) < 10) begin
			in_valid <= 1'b0;
			repeat ($urandom_range(1, 6)) @(posedge clk);
		end
		in_valid <= 1'b1;
		tick_count <= cnt;
		@(posedge clk);
		while (!in_ready)
			@(posedge clk);
		predict_level(cnt);
	endtask

	// Waits until every expected sample is in, then for the block to settle.
	task automatic drain();
		in_valid <= 1'b0;
		while (expected_levels.size() != 0)
			@(posedge clk);
		repeat (100) @(posedge clk);
	endtask

	// Directed cases: zero period, every waveform code with a repeated count, and edge values.
	task automatic test_directed();
		set_all(WAVE_RAMP_UP, 16'd0, 16'd256, 16'd256, 16'd256, 32'd0);
		send_tick(32'd5);
		send_tick(32'd0);
		write_reg(REG_PERIOD, 32'd100);
		for (int w = 0; w < 8; w++) begin
			write_reg(REG_WAVEFORM, w);
			send_tick(32'd25 + w);
			send_tick(32'd25 + w);
		end
		drain();
		set_all(WAVE_TRIANGLE, 16'hFFFF, 16'h7FFF, 16'h8000, 16'hFFFF, 32'hFFFF_FFFF);
		send_tick(32'hFFFF_FFFF);
		send_tick(32'h7FFF_FFFF);
		write_reg(REG_WAVEFORM, {29'd0, WAVE_RAMP_DOWN});
		send_tick(32'h0000_0000);
		send_tick(32'h8000_0000);
		write_reg(REG_AMPLITUDE, 32'h8000);
		send_tick(32'h1234_5678);
		write_reg(REG_WAVEFORM, {29'd0, WAVE_SINE});
		send_tick(32'hFFFF_0000);
		write_reg(REG_WAVEFORM, {29'd0, WAVE_COSINE});
		send_tick(32'h0000_FFFF);
		write_reg(3'd7, 32'hFFFF_FFFF);
		write_reg(3'd6, 32'h0);
		send_tick(32'h0000_0001);
		drain();
	endtask

	// Random configurations, each followed by a run of tick counts.
	task automatic test_random();
		logic [31:0] cnt;
		for (int phase_no = 0; phase_no < 24; phase_no++) begin
			quiet_in = (phase_no == 10);
			quiet_out = (phase_no == 10);
			set_all(3'($urandom_range(7)),
				($urandom_range(9) == 0) ? 16'd0 :
				($urandom_range(3) == 0) ? 16'($urandom) : 16'($urandom_range(1, 64)),
				16'($urandom), 16'($urandom),
				($urandom_range(3) == 0) ? 16'($urandom) : 16'($urandom_range(0, 1024)),
				$urandom);
			cnt = $urandom;
			for (int n = 0; n < 30; n++) begin
				case ($urandom_range(9))
					0: ;
					1: cnt = $urandom;
					default: cnt = cnt + $urandom_range(1, 5);
				endcase
				send_tick(cnt);
			end
			drain();
		end
		quiet_in = 1'b0;
		quiet_out = 1'b0;
	endtask

	// Sample checker and output back-pressure.
	always @(posedge clk) begin
		if (arst_n && out_valid && out_ready) begin
			if (expected_levels.size() == 0) begin
				mismatches++;
				if (mismatches <= 10)
					$display("Unexpected sample: level %0d", level);
			end else begin
				if (level !== expected_levels[0]) begin
					mismatches++;
					if (mismatches <= 10)
						$display("Level mismatch: expected %0d, actual %0d",
							expected_levels[0], level);
				end
				void'(expected_levels.pop_front());
			end
		end
		out_ready <= quiet_out || ($urandom_range(99) >= 10);
	end

	// Main sequence.
	initial begin
		arst_n = 1'b0;
		cfg_we = 1'b0;
		cfg_index = '0;
		cfg_data = '0;
		in_valid = 1'b0;
		tick_count = '0;
		out_ready = 1'b1;
		mismatches = 0;
		quiet_in = 1'b0;
		quiet_out = 1'b0;
		sh_wave = WAVE_NONE;
		sh_period = 16'd0;
		sh_amp = 16'sd256;
		sh_amp_max = 16'sd256;
		sh_scale = 16'd256;
		sh_start = 32'd0;
		sh_last = 32'd0;
		repeat (6) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);
		test_directed();
		test_random();
		if (mismatches == 0 && expected_levels.size() == 0)
			$display("Testbench completed without errors");
		else
			$display("Testbench completed WITH ERRORS");
		$finish;
	end

	// Timeout watchdog.
	initial begin
		#20ms;
		$display("Testbench completed WITH ERRORS");
		$finish;
	end

endmodule
